[rtl/tkh_pkg.sv]
package tkh_pkg;

    localparam int ID_W     = 32;
    localparam int DIST_W   = 31;
    localparam int KEEP_W   = 5;
    localparam int CMD_W    = 2;
    localparam int KIND_W   = 2;

    // Reset value of the kept-count register.
    localparam logic [KEEP_W-1:0] KEEP_RESET = 5'd16;

    // Distance bits of positive infinity, the threshold of a heap not yet full.
    localparam logic [DIST_W-1:0] INF_DIST = 31'h7F80_0000;

    // Command codes of an input request.
    localparam logic [CMD_W-1:0] CMD_PUSH  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_DRAIN = 2'd1;
    localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;

    // Kind codes of a result request.
    localparam logic [KIND_W-1:0] KIND_REPLY = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENTRY = 2'd1;
    localparam logic [KIND_W-1:0] KIND_EMPTY = 2'd2;

    // One heap slot.
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [DIST_W-1:0] distance;
    } t_entry;

    // One result as held in the output register.
    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [ID_W-1:0]   entry_id;
        logic [DIST_W-1:0] entry_distance;
        logic [DIST_W-1:0] threshold;
        logic              is_full;
        logic              last;
    } t_result;

    // Sequencer states.
    typedef enum logic [3:0] {
        S_IDLE,
        S_SU_RD,
        S_SU_CMP,
        S_SD_RDL,
        S_SD_RDR,
        S_SD_CMP,
        S_PUSH_REPLY,
        S_DR_CHK,
        S_DR_SWAP,
        S_EM_RD,
        S_EM_LD,
        S_DR_EMPTY
    } t_state;

endpackage

[rtl/tkh_ifs.sv]
// Input request channel: command and candidate.
interface tkh_in_if;
    import tkh_pkg::*;

    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  cmd;
    logic [ID_W-1:0]   item_id;
    logic [DIST_W-1:0] distance;

    modport source (output valid, output cmd, output item_id, output distance, input ready);
    modport sink   (input valid, input cmd, input item_id, input distance, output ready);
endinterface

// Result request channel.
interface tkh_out_if;
    import tkh_pkg::*;

    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [ID_W-1:0]   entry_id;
    logic [DIST_W-1:0] entry_distance;
    logic [DIST_W-1:0] threshold;
    logic              is_full;
    logic              last;

    modport source (output valid, output kind, output entry_id, output entry_distance,
                    output threshold, output is_full, output last, input ready);
    modport sink   (input valid, input kind, input entry_id, input entry_distance,
                    input threshold, input is_full, input last, output ready);
endinterface

// Configuration write channel for the kept-count register.
interface tkh_cfg_if;
    import tkh_pkg::*;

    logic              valid;
    logic              ready;
    logic [KEEP_W-1:0] data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[rtl/tkh_ram.sv]
module tkh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic             i_re,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // Registered read port; the data holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[rtl/top_k_max_heap.sv]
// Top-k selector: keeps the keep_count smallest distances pushed so far, with
// their ids, as a binary max-heap in one single-port-read RAM, so the root is
// the current k-th distance. Every push answers with that threshold (or
// infinity while the heap is not full); a drain heap-sorts the RAM in place,
// returns the entries in ascending order with last on the final one, and
// empties the heap; a drain of an empty heap returns one empty marker; a
// clear empties the heap. Input ready is high only while the sequencer is
// idle. The heap RAM's one read port sets the pace: a push that adds an
// entry sifts up with a parent read and then a compare per level, a push
// that replaces the root sifts down with a left read, a right read while
// the right child is live and then a compare per level, and each push ends
// with its reply. A drain sorts the RAM, then reads and returns each entry.
// The fill count alone says which slots are valid, so the RAM needs no
// clearing pass after reset. A copy of the root slot lives in registers.
module top_k_max_heap #(
    parameter int MAX_K = 16
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    tkh_in_if.sink        i_in,
    tkh_out_if.source     o_out,
    tkh_cfg_if.sink       i_cfg
);
    import tkh_pkg::*;

    localparam int AW   = (MAX_K > 1) ? $clog2(MAX_K) : 1;
    localparam int CW   = $clog2(MAX_K + 1);
    localparam int IXW  = CW + 1;
    localparam int CMPW = (CW > KEEP_W) ? CW : KEEP_W;
    localparam int EW   = ID_W + DIST_W;

    t_state            r_state, n_state;
    logic [CW-1:0]     r_fill, n_fill;
    logic [KEEP_W-1:0] r_keep;
    logic [AW-1:0]     r_i, n_i;
    logic [CW-1:0]     r_size, n_size;
    logic [AW-1:0]     r_idx, n_idx;
    t_entry            r_v, n_v;
    t_entry            r_left, n_left;
    t_entry            r_root;
    logic              r_drain, n_drain;
    t_result           r_out, n_out;
    logic              r_out_valid;
    logic              out_load;

    logic              ram_we;
    logic [AW-1:0]     ram_waddr;
    t_entry            ram_wdata;
    logic              ram_re;
    logic [AW-1:0]     ram_raddr;
    logic [EW-1:0]     ram_rdata_raw;
    t_entry            rdata;

    logic [CW-1:0]     eff_k;
    logic [CMPW-1:0]   keep_x;
    logic [IXW-1:0]    left_x, right_x;
    logic              left_in, right_in;
    logic [AW-1:0]     parent;
    logic              out_free;
    logic              in_acc;
    logic              is_last;
    logic              full;
    logic              big_left;
    t_entry            big_e;

    // Heap storage.
    tkh_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_K)
    ) u_heap (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_re    (ram_re),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata_raw)
    );

    assign rdata = t_entry'(ram_rdata_raw);

    // Effective k: zero acts as one, values above the depth act as the depth.
    always_comb begin
        keep_x = CMPW'(r_keep);
        if (r_keep == '0) begin
            eff_k = CW'(1);
        end else if (keep_x > CMPW'(MAX_K)) begin
            eff_k = CW'(MAX_K);
        end else begin
            eff_k = CW'(keep_x);
        end
    end

    // Tree navigation around the current hole.
    assign left_x   = IXW'({r_i, 1'b1});
    assign right_x  = left_x + IXW'(1);
    assign left_in  = left_x < IXW'(r_size);
    assign right_in = right_x < IXW'(r_size);
    assign parent   = (r_i - AW'(1)) >> 1;

    assign out_free = !r_out_valid || o_out.ready;
    assign in_acc   = i_in.valid && i_in.ready;
    assign is_last  = (CW'(r_idx) + CW'(1)) == r_fill;
    assign full     = r_fill >= eff_k;
    assign big_left = r_left.distance > r_v.distance;
    assign big_e    = big_left ? r_left : r_v;

    assign i_in.ready = (r_state == S_IDLE);
    assign i_cfg.ready = 1'b1;

    // Sequencer: every RAM write and the read that follows it sit in different
    // cycles, and no step reads a slot written in the same cycle.
    always_comb begin
        n_state   = r_state;
        n_fill    = r_fill;
        n_i       = r_i;
        n_size    = r_size;
        n_idx     = r_idx;
        n_v       = r_v;
        n_left    = r_left;
        n_drain   = r_drain;
        n_out     = r_out;
        out_load  = 1'b0;
        ram_we    = 1'b0;
        ram_waddr = r_i;
        ram_wdata = r_v;
        ram_re    = 1'b0;
        ram_raddr = r_idx;

        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    case (i_in.cmd)
                        CMD_PUSH: begin
                            n_v.id       = i_in.item_id;
                            n_v.distance = i_in.distance;
                            if (r_fill < eff_k) begin
                                n_i     = AW'(r_fill);
                                n_fill  = r_fill + CW'(1);
                                n_state = S_SU_RD;
                            end else if (i_in.distance < r_root.distance) begin
                                n_i     = '0;
                                n_size  = r_fill;
                                n_drain = 1'b0;
                                n_state = S_SD_RDL;
                            end else begin
                                n_state = S_PUSH_REPLY;
                            end
                        end
                        CMD_DRAIN: begin
                            if (r_fill == '0) begin
                                n_state = S_DR_EMPTY;
                            end else begin
                                n_size  = r_fill;
                                n_drain = 1'b1;
                                n_state = S_DR_CHK;
                            end
                        end
                        CMD_CLEAR: begin
                            n_fill = '0;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            S_SU_RD: begin
                if (r_i == '0) begin
                    ram_we  = 1'b1;
                    n_state = S_PUSH_REPLY;
                end else begin
                    ram_re    = 1'b1;
                    ram_raddr = parent;
                    n_state   = S_SU_CMP;
                end
            end

            S_SU_CMP: begin
                ram_we = 1'b1;
                if (r_v.distance <= rdata.distance) begin
                    n_state = S_PUSH_REPLY;
                end else begin
                    ram_wdata = rdata;
                    n_i       = parent;
                    n_state   = S_SU_RD;
                end
            end

            S_SD_RDL: begin
                if (left_in) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(left_x);
                    n_state   = S_SD_RDR;
                end else begin
                    ram_we  = 1'b1;
                    n_state = r_drain ? S_DR_CHK : S_PUSH_REPLY;
                end
            end

            S_SD_RDR: begin
                n_left = rdata;
                if (right_in) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(right_x);
                    n_state   = S_SD_CMP;
                end else if (rdata.distance > r_v.distance) begin
                    ram_we    = 1'b1;
                    ram_wdata = rdata;
                    n_i       = AW'(left_x);
                    n_state   = S_SD_RDL;
                end else begin
                    ram_we  = 1'b1;
                    n_state = r_drain ? S_DR_CHK : S_PUSH_REPLY;
                end
            end

            S_SD_CMP: begin
                ram_we = 1'b1;
                if (rdata.distance > big_e.distance) begin
                    ram_wdata = rdata;
                    n_i       = AW'(right_x);
                    n_state   = S_SD_RDL;
                end else if (big_left) begin
                    ram_wdata = r_left;
                    n_i       = AW'(left_x);
                    n_state   = S_SD_RDL;
                end else begin
                    n_state = r_drain ? S_DR_CHK : S_PUSH_REPLY;
                end
            end

            S_PUSH_REPLY: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    n_out.kind           = KIND_REPLY;
                    n_out.entry_id       = '0;
                    n_out.entry_distance = '0;
                    n_out.threshold      = full ? r_root.distance : INF_DIST;
                    n_out.is_full        = full;
                    n_out.last           = 1'b0;
                    n_state              = S_IDLE;
                end
            end

            // Heap-sort step: swap root with last live slot, or start emitting.
            S_DR_CHK: begin
                if (r_size > CW'(1)) begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(r_size - CW'(1));
                    n_size    = r_size - CW'(1);
                    n_state   = S_DR_SWAP;
                end else begin
                    n_idx   = '0;
                    n_state = S_EM_RD;
                end
            end

            S_DR_SWAP: begin
                n_v       = rdata;
                ram_we    = 1'b1;
                ram_waddr = AW'(r_size);
                ram_wdata = r_root;
                n_i       = '0;
                n_state   = S_SD_RDL;
            end

            S_EM_RD: begin
                ram_re    = 1'b1;
                ram_raddr = r_idx;
                n_state   = S_EM_LD;
            end

            S_EM_LD: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    n_out.kind           = KIND_ENTRY;
                    n_out.entry_id       = rdata.id;
                    n_out.entry_distance = rdata.distance;
                    n_out.threshold      = '0;
                    n_out.is_full        = 1'b0;
                    n_out.last           = is_last;
                    if (is_last) begin
                        n_fill  = '0;
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + AW'(1);
                        n_state = S_EM_RD;
                    end
                end
            end

            S_DR_EMPTY: begin
                if (out_free) begin
                    out_load             = 1'b1;
                    n_out.kind           = KIND_EMPTY;
                    n_out.entry_id       = '0;
                    n_out.entry_distance = '0;
                    n_out.threshold      = '0;
                    n_out.is_full        = 1'b0;
                    n_out.last           = 1'b1;
                    n_state              = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // State register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill      <= '0;
            r_keep      <= KEEP_RESET;
            r_drain     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_fill  <= n_fill;
            r_drain <= n_drain;
            if (i_cfg.valid && i_cfg.ready) begin
                r_keep <= i_cfg.data;
            end
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Datapath registers; the root copy follows every write to slot zero.
    always_ff @(posedge i_clk) begin
        r_i    <= n_i;
        r_size <= n_size;
        r_idx  <= n_idx;
        r_v    <= n_v;
        r_left <= n_left;
        r_out  <= n_out;
        if (ram_we && ram_waddr == '0) begin
            r_root <= ram_wdata;
        end
    end

    // Result channel.
    assign o_out.valid          = r_out_valid;
    assign o_out.kind           = r_out.kind;
    assign o_out.entry_id       = r_out.entry_id;
    assign o_out.entry_distance = r_out.entry_distance;
    assign o_out.threshold      = r_out.threshold;
    assign o_out.is_full        = r_out.is_full;
    assign o_out.last           = r_out.last;

    // The fill count never passes the heap depth.
    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= CW'(MAX_K))
        else $error("fill count above heap depth");

    // Every heap write lands inside the live part of the heap.
    a_write_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ram_we |-> (CW'(ram_waddr) < r_fill))
        else $error("heap write outside live slots");

    // A clear request leaves an empty heap.
    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && i_in.cmd == CMD_CLEAR) |=> (r_fill == '0))
        else $error("clear did not empty heap");

    // A push reply never carries the last flag.
    a_reply_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.kind == KIND_REPLY) |-> !o_out.last)
        else $error("push reply flagged last");

endmodule

[bench/tkh_topk_checker.sv]
// Watches the request, result and register channels of the top-k heap.
// It keeps its own copy of the heap and the kept count, works out the results
// of every accepted request, and compares the results in arrival order.
module tkh_topk_checker #(
    parameter int MAX_K = 16
) (
    input  logic i_clk,
    input  logic i_rst_n,
    tkh_in_if    i_in,
    tkh_out_if   i_out,
    tkh_cfg_if   i_cfg,
    output int   o_mismatches,
    output int   o_outstanding
);
    import tkh_pkg::*;

    // Shadow heap, its fill level and the kept-count register.
    logic [ID_W-1:0]   slot_id   [MAX_K];
    logic [DIST_W-1:0] slot_dist [MAX_K];
    int                fill;
    logic [KEEP_W-1:0] keep_count;

    // Results still owed by the block, oldest first.
    t_result           awaited_results [$];
    int                errors = 0;

    function automatic void swap_slots(input int a, input int b);
        logic [ID_W-1:0]   tmp_id;
        logic [DIST_W-1:0] tmp_dist;
        tmp_id       = slot_id[a];
        slot_id[a]   = slot_id[b];
        slot_id[b]   = tmp_id;
        tmp_dist     = slot_dist[a];
        slot_dist[a] = slot_dist[b];
        slot_dist[b] = tmp_dist;
    endfunction

    // The right child wins only when it is strictly larger than the left one,
    // and a node moves down only below a strictly larger child.
    function automatic void sift_down(input int n, input int start);
        int  node;
        int  big;
        bit  done;
        node = start;
        done = 1'b0;
        while (!done) begin
            big = node;
            if (2 * node + 1 < n && slot_dist[2 * node + 1] > slot_dist[big]) begin
                big = 2 * node + 1;
            end
            if (2 * node + 2 < n && slot_dist[2 * node + 2] > slot_dist[big]) begin
                big = 2 * node + 2;
            end
            if (big == node) begin
                done = 1'b1;
            end else begin
                swap_slots(node, big);
                node = big;
            end
        end
    endfunction

    // Updates the shadow heap for one request and queues what it answers.
    function automatic void predict_request(input logic [CMD_W-1:0]  cmd,
                                            input logic [ID_W-1:0]   id,
                                            input logic [DIST_W-1:0] item_dist);
        int      k;
        int      node;
        int      n;
        t_result res;
        // A kept count of zero acts as one, anything above the depth as the depth.
        if (keep_count == 0) begin
            k = 1;
        end else if (keep_count > MAX_K) begin
            k = MAX_K;
        end else begin
            k = int'(keep_count);
        end
        res = '0;
        case (cmd)
            CMD_PUSH: begin
                if (fill < k) begin
                    slot_id[fill]   = id;
                    slot_dist[fill] = item_dist;
                    node = fill;
                    fill++;
                    // Sift-up stops once the child no longer exceeds its parent.
                    while (node > 0 && slot_dist[node] > slot_dist[(node - 1) / 2]) begin
                        swap_slots(node, (node - 1) / 2);
                        node = (node - 1) / 2;
                    end
                end else if (item_dist < slot_dist[0]) begin
                    // A full heap takes only a strictly smaller distance.
                    slot_id[0]   = id;
                    slot_dist[0] = item_dist;
                    sift_down(fill, 0);
                end
                res.kind      = KIND_REPLY;
                res.is_full   = (fill >= k);
                res.threshold = res.is_full ? slot_dist[0] : INF_DIST;
                awaited_results.push_back(res);
            end
            CMD_DRAIN: begin
                if (fill == 0) begin
                    res.kind = KIND_EMPTY;
                    res.last = 1'b1;
                    awaited_results.push_back(res);
                end else begin
                    // In-place heap sort leaves the slots in ascending order.
                    for (n = fill - 1; n > 0; n--) begin
                        swap_slots(0, n);
                        sift_down(n, 0);
                    end
                    for (node = 0; node < fill; node++) begin
                        res                = '0;
                        res.kind           = KIND_ENTRY;
                        res.entry_id       = slot_id[node];
                        res.entry_distance = slot_dist[node];
                        res.last           = (node == fill - 1);
                        awaited_results.push_back(res);
                    end
                    fill = 0;
                end
            end
            CMD_CLEAR: begin
                fill = 0;
            end
            default: begin
            end
        endcase
    endfunction

    // Results are checked before the request of the same edge is predicted,
    // since a request cannot be answered on the edge that accepts it.
    always @(posedge i_clk) begin : watch
        t_result seen;
        t_result want;
        if (!i_rst_n) begin
            fill       = 0;
            keep_count = KEEP_RESET;
            awaited_results.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                seen.kind           = i_out.kind;
                seen.entry_id       = i_out.entry_id;
                seen.entry_distance = i_out.entry_distance;
                seen.threshold      = i_out.threshold;
                seen.is_full        = i_out.is_full;
                seen.last           = i_out.last;
                if (awaited_results.size() == 0) begin
                    errors++;
                    if (errors <= 10) begin
                        $display("%0t: unexpected result kind %0d id %h dist %h thr %h",
                                 $time, seen.kind, seen.entry_id, seen.entry_distance,
                                 seen.threshold);
                    end
                end else begin
                    want = awaited_results.pop_front();
                    if (seen.kind !== want.kind || seen.entry_id !== want.entry_id ||
                        seen.entry_distance !== want.entry_distance ||
                        seen.threshold !== want.threshold ||
                        seen.is_full !== want.is_full || seen.last !== want.last) begin
                        errors++;
                        if (errors <= 10) begin
                            $display("%0t: expected kind %0d id %h dist %h thr %h full %b last %b",
                                     $time, want.kind, want.entry_id, want.entry_distance,
                                     want.threshold, want.is_full, want.last);
                            $display("%0t: actual   kind %0d id %h dist %h thr %h full %b last %b",
                                     $time, seen.kind, seen.entry_id, seen.entry_distance,
                                     seen.threshold, seen.is_full, seen.last);
                        end
                    end
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                keep_count = i_cfg.data;
            end
            if (i_in.valid && i_in.ready) begin
                predict_request(i_in.cmd, i_in.item_id, i_in.distance);
            end
        end
        o_mismatches  <= errors;
        o_outstanding <= awaited_results.size();
    end

endmodule

[bench/tb.sv]
// Drives the top-k heap with directed and random requests under random
// back-pressure; the checker beside the block predicts and compares.
module tb;
    import tkh_pkg::*;

    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int PHASE_REQUESTS  = 60;

    logic clk = 1'b0;
    logic rst_n;
    int   mismatches;
    int   outstanding;
    logic hold_off_req;
    int   burst_left;

    tkh_in_if  in_if ();
    tkh_out_if out_if ();
    tkh_cfg_if cfg_if ();

    top_k_max_heap #(
        .MAX_K (16)
    ) dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_in    (in_if),
        .o_out   (out_if),
        .i_cfg   (cfg_if)
    );

    tkh_topk_checker #(
        .MAX_K (16)
    ) u_checker (
        .i_clk         (clk),
        .i_rst_n       (rst_n),
        .i_in          (in_if),
        .i_out         (out_if),
        .i_cfg         (cfg_if),
        .o_mismatches  (mismatches),
        .o_outstanding (outstanding)
    );

    always #10 clk = ~clk;

    // Offers one request; bursts of random length are separated by random gaps.
    task automatic send_request(input logic [CMD_W-1:0]  cmd,
                                input logic [ID_W-1:0]   id,
                                input logic [DIST_W-1:0] item_dist);
        int gap;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = $urandom_range(1, 30);
            if (gap != 0) begin
                in_if.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        in_if.valid    <= 1'b1;
        in_if.cmd      <= cmd;
        in_if.item_id  <= id;
        in_if.distance <= item_dist;
        do @(posedge clk); while (!in_if.ready);
    endtask

    // Stops offering and waits until every predicted result has come back.
    task automatic wait_drained();
        in_if.valid <= 1'b0;
        burst_left = 0;
        @(posedge clk);
        while (outstanding != 0) @(posedge clk);
    endtask

    task automatic write_keep_count(input logic [KEEP_W-1:0] value);
        wait_drained();
        // A clear or an unused command leaves no result behind, so give the
        // sequencer time to return to idle.
        repeat (20) @(posedge clk);
        cfg_if.valid <= 1'b1;
        cfg_if.data  <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
    endtask

    // Result side: stalls on patterns that change after random stretches, and
    // once holds off for a long stretch on request.
    initial begin : result_receiver
        int stretch;
        int mode;
        out_if.ready <= 1'b0;
        forever begin
            stretch = $urandom_range(5, 60);
            mode    = $urandom_range(0, 3);
            repeat (stretch) begin
                @(posedge clk);
                if (hold_off_req) begin
                    out_if.ready <= 1'b0;
                    repeat (HOLD_OFF_CYCLES) @(posedge clk);
                end
                case (mode)
                    0:       out_if.ready <= 1'b1;
                    1:       out_if.ready <= 1'($urandom_range(0, 1));
                    2:       out_if.ready <= ($urandom_range(0, 3) == 0);
                    default: out_if.ready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    initial begin : stimulus
        logic [KEEP_W-1:0] phase_keep [8] = '{5'd1, 5'd16, 5'd0, 5'd31, 5'd5, 5'd3,
                                              5'd12, 5'd17};
        int                pick;
        logic [DIST_W-1:0] cand_dist;
        in_if.valid    <= 1'b0;
        in_if.cmd      <= CMD_PUSH;
        in_if.item_id  <= '0;
        in_if.distance <= '0;
        cfg_if.valid   <= 1'b0;
        cfg_if.data    <= '0;
        hold_off_req   <= 1'b0;
        burst_left = 0;
        rst_n <= 1'b0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset keep count: empty drain, extreme fields, ties, unused command.
        send_request(CMD_DRAIN, 32'h0, 31'h0);
        send_request(CMD_PUSH, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_request(CMD_PUSH, 32'h0, 31'h0);
        send_request(CMD_PUSH, 32'h1, INF_DIST);
        send_request(CMD_PUSH, 32'h2, 31'h0);
        send_request(CMD_UNUSED, 32'hFFFF_FFFF, 31'h7FFF_FFFF);
        send_request(CMD_DRAIN, 32'h0, 31'h0);
        send_request(CMD_CLEAR, 32'h0, 31'h0);

        // Small heap: a push equal to the root is rejected, a smaller one replaces it.
        write_keep_count(5'd2);
        send_request(CMD_PUSH, 32'd10, 31'd100);
        send_request(CMD_PUSH, 32'd11, 31'd50);
        send_request(CMD_PUSH, 32'd12, 31'd100);
        send_request(CMD_PUSH, 32'd13, 31'd99);
        send_request(CMD_PUSH, 32'd14, 31'h7FFF_FFFF);
        send_request(CMD_CLEAR, 32'h0, 31'h0);
        send_request(CMD_DRAIN, 32'h0, 31'h0);

        // A kept count of zero behaves as one.
        write_keep_count(5'd0);
        send_request(CMD_PUSH, 32'd20, 31'd5);
        send_request(CMD_PUSH, 32'd21, 31'd5);
        send_request(CMD_PUSH, 32'd22, 31'd3);
        send_request(CMD_DRAIN, 32'h0, 31'h0);

        // Kept count lowered below the fill level: the extra entries stay.
        write_keep_count(5'd31);
        send_request(CMD_PUSH, 32'd30, 31'd60);
        send_request(CMD_PUSH, 32'd31, 31'd10);
        send_request(CMD_PUSH, 32'd32, 31'd40);
        send_request(CMD_PUSH, 32'd33, 31'd10);
        send_request(CMD_PUSH, 32'd34, 31'd70);
        write_keep_count(5'd3);
        send_request(CMD_PUSH, 32'd40, 31'd15);
        send_request(CMD_PUSH, 32'd41, 31'd80);
        send_request(CMD_DRAIN, 32'h0, 31'h0);

        // Random phases, one per kept-count setting; the heap carries over.
        foreach (phase_keep[p]) begin
            write_keep_count(phase_keep[p]);
            if (p == 2) begin
                hold_off_req <= 1'b1;
                @(posedge clk);
                hold_off_req <= 1'b0;
            end
            for (int j = 0; j < PHASE_REQUESTS; j++) begin
                pick = $urandom_range(0, 99);
                case ($urandom_range(0, 9))
                    0, 1, 2, 3: cand_dist = DIST_W'($urandom_range(0, 15));
                    4, 5:       cand_dist = DIST_W'($urandom_range(32'h3F00_0000,
                                                                   32'h4300_0000));
                    6:          cand_dist = INF_DIST;
                    7:          cand_dist = 31'h7FFF_FFFF - DIST_W'($urandom_range(0, 3));
                    default:    cand_dist = DIST_W'($urandom);
                endcase
                if (pick < 85) begin
                    send_request(CMD_PUSH, $urandom, cand_dist);
                end else if (pick < 93) begin
                    send_request(CMD_DRAIN, $urandom, cand_dist);
                end else if (pick < 97) begin
                    send_request(CMD_CLEAR, $urandom, cand_dist);
                end else begin
                    send_request(CMD_UNUSED, $urandom, cand_dist);
                end
            end
        end

        wait_drained();
        repeat (50) @(posedge clk);
        if (mismatches == 0 && outstanding == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // Watchdog far beyond the slowest correct run.
    initial begin : watchdog
        #30_000_000;
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

[filelist.f]
rtl/tkh_pkg.sv
rtl/tkh_ifs.sv
rtl/tkh_ram.sv
rtl/top_k_max_heap.sv
bench/tkh_topk_checker.sv
bench/tb.sv
